FILE: hdl/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types, constants and helpers of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int unsigned DATA_W            = 16;
  localparam int unsigned KF_W              = 3 * DATA_W;
  localparam int unsigned KF_REGS           = 8;
  localparam int unsigned KF_IDX_W          = $clog2(KF_REGS);
  localparam int unsigned NUM_KEYFRAMES_DEF = 8;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  // one quotient bit per divider stage
  localparam int unsigned DIV_STAGES        = DATA_W;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [KF_W-1:0]   kf_t;
  typedef logic [PROD_W-1:0] prod_t;

  // values that ride alongside the divider
  typedef struct packed {
    data_t base_t;
    data_t base_b;
    logic  neg_t;
    logic  neg_b;
  } side_t;

  function automatic data_t kf_pos(input kf_t k);
    return k[KF_W-1 -: DATA_W];
  endfunction

  function automatic data_t kf_temp(input kf_t k);
    return k[2*DATA_W-1 -: DATA_W];
  endfunction

  function automatic data_t kf_bri(input kf_t k);
    return k[DATA_W-1:0];
  endfunction

  // one restoring division step: upper half holds the remainder, a quotient
  // bit shifts in at the bottom
  function automatic prod_t div_step(input prod_t acc, input data_t den);
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    trial = acc[PROD_W-1 -: DATA_W+1];
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[DATA_W-1:0], acc[DATA_W-2:0], 1'b1};
    end else begin
      return {trial[DATA_W-1:0], acc[DATA_W-2:0], 1'b0};
    end
  endfunction

endpackage

FILE: hdl/keyframe_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top
// Piecewise linear lookup of colour temperature and brightness over a table
// of keyframes, fully pipelined.
// ----------------------------------------------------------------------------
// One word is accepted in every cycle that start is high; busy is held low.
// Each result appears on the out_ ports for one cycle with out_strobe high,
// in input order. The receiver cannot stall the block. The pipeline holds
// the neighbour search (compare, then select), subtraction, multiply, the
// 16-stage divider (one quotient bit per stage) and one output register.
// Keyframe registers are written through the cfg_ port, which is always
// ready; write them only while no word is in flight.
module keyframe_linear_interpolator_top #(
  parameter int unsigned NUM_KEYFRAMES = kli_pkg::NUM_KEYFRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [kli_pkg::DATA_W-1:0]      in_day_fraction,
  output logic                            out_strobe,
  output logic [kli_pkg::DATA_W-1:0]      out_colour_temperature,
  output logic [kli_pkg::DATA_W-1:0]      out_brightness_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kli_pkg::KF_IDX_W-1:0]    cfg_index,
  input  logic [kli_pkg::KF_W-1:0]        cfg_wdata
);

  localparam int unsigned NR  = kli_pkg::KF_REGS;
  localparam int unsigned IW  = kli_pkg::KF_IDX_W;
  localparam int unsigned LAT = 5 + kli_pkg::DIV_STAGES;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_KEYFRAMES - 1);

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // keyframe table
  kli_pkg::kf_t kf_r [NR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NR; i++) begin
        kf_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      kf_r[cfg_index] <= cfg_wdata;
    end
  end

  // stage 1: compare input against every keyframe position
  logic              v1_r;
  kli_pkg::data_t    x1_r;
  logic [NR-1:0]     ge1_r, ge1_nxt;
  logic [NR-1:0]     eq1_r, eq1_nxt;

  always_comb begin
    for (int i = 0; i < NR; i++) begin
      ge1_nxt[i] = (i < NUM_KEYFRAMES) && (kli_pkg::kf_pos(kf_r[i]) >= in_day_fraction);
      eq1_nxt[i] = (i < NUM_KEYFRAMES) && (kli_pkg::kf_pos(kf_r[i]) == in_day_fraction);
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= in_day_fraction;
    ge1_r <= ge1_nxt;
    eq1_r <= eq1_nxt;
  end

  // stage 2: first keyframe at or above the input, select the neighbours
  logic              v2_r;
  kli_pkg::data_t    x2_r;
  kli_pkg::kf_t      lo2_r, lo2_nxt;
  kli_pkg::kf_t      hi2_r, hi2_nxt;
  logic              pass2_r, pass2_nxt;
  logic              found;
  logic [IW-1:0]     first_idx;
  logic [IW-1:0]     sel_idx;
  kli_pkg::kf_t      prev_kf [NR];
  kli_pkg::kf_t      cur_kf, prv_kf;

  always_comb begin
    for (int i = 0; i < NR; i++) begin
      prev_kf[i] = (i == 0) ? kf_r[0] : kf_r[(i == 0) ? 0 : i - 1];
    end
  end

  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (ge1_r[i]) begin
        found     = 1'b1;
        first_idx = IW'(i);
      end
    end
    sel_idx   = found ? first_idx : LAST_IDX;
    cur_kf    = kf_r[sel_idx];
    prv_kf    = prev_kf[sel_idx];
    // past the table, on a keyframe, or below the first: no interpolation
    pass2_nxt = !found || eq1_r[first_idx] || (first_idx == '0);
    hi2_nxt   = cur_kf;
    lo2_nxt   = pass2_nxt ? cur_kf : prv_kf;
  end

  always_ff @(posedge clk) begin
    x2_r    <= x1_r;
    lo2_r   <= lo2_nxt;
    hi2_r   <= hi2_nxt;
    pass2_r <= pass2_nxt;
  end

  // stage 3: offsets and spans; lo < x < hi whenever interpolating
  logic              v3_r;
  kli_pkg::data_t    a3_r, a3_nxt;
  kli_pkg::data_t    d3_r, d3_nxt;
  kli_pkg::data_t    dt3_r, dt3_nxt;
  kli_pkg::data_t    db3_r, db3_nxt;
  kli_pkg::side_t    side3_r, side3_nxt;
  kli_pkg::data_t    t_lo, t_hi, b_lo, b_hi;

  always_comb begin
    t_lo = kli_pkg::kf_temp(lo2_r);
    t_hi = kli_pkg::kf_temp(hi2_r);
    b_lo = kli_pkg::kf_bri(lo2_r);
    b_hi = kli_pkg::kf_bri(hi2_r);
    a3_nxt = pass2_r ? '0 : x2_r - kli_pkg::kf_pos(lo2_r);
    d3_nxt = pass2_r ? kli_pkg::DATA_W'(1)
                     : kli_pkg::kf_pos(hi2_r) - kli_pkg::kf_pos(lo2_r);
    dt3_nxt = (t_hi >= t_lo) ? t_hi - t_lo : t_lo - t_hi;
    db3_nxt = (b_hi >= b_lo) ? b_hi - b_lo : b_lo - b_hi;
    side3_nxt.base_t = t_lo;
    side3_nxt.base_b = b_lo;
    side3_nxt.neg_t  = t_hi < t_lo;
    side3_nxt.neg_b  = b_hi < b_lo;
  end

  always_ff @(posedge clk) begin
    a3_r    <= a3_nxt;
    d3_r    <= d3_nxt;
    dt3_r   <= dt3_nxt;
    db3_r   <= db3_nxt;
    side3_r <= side3_nxt;
  end

  // stage 4: products
  logic              v4_r;
  kli_pkg::prod_t    pt4_r, pb4_r;
  kli_pkg::data_t    d4_r;
  kli_pkg::side_t    side4_r;

  always_ff @(posedge clk) begin
    pt4_r   <= a3_r * dt3_r;
    pb4_r   <= a3_r * db3_r;
    d4_r    <= d3_r;
    side4_r <= side3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // divider
  logic              dv_vld;
  kli_pkg::data_t    q_t, q_b;
  kli_pkg::side_t    dv_side;

  kli_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (v4_r),
    .in_num_t  (pt4_r),
    .in_num_b  (pb4_r),
    .in_den    (d4_r),
    .in_side   (side4_r),
    .out_vld   (dv_vld),
    .out_quo_t (q_t),
    .out_quo_b (q_b),
    .out_side  (dv_side)
  );

  // output: quotient is below the span, so no saturation is needed
  logic              strobe_r;
  kli_pkg::data_t    temp_r, temp_nxt;
  kli_pkg::data_t    bri_r, bri_nxt;

  always_comb begin
    temp_nxt = dv_side.neg_t ? dv_side.base_t - q_t : dv_side.base_t + q_t;
    bri_nxt  = dv_side.neg_b ? dv_side.base_b - q_b : dv_side.base_b + q_b;
  end

  always_ff @(posedge clk) begin
    temp_r <= temp_nxt;
    bri_r  <= bri_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_vld;
    end
  end

  assign out_strobe             = strobe_r;
  assign out_colour_temperature = temp_r;
  assign out_brightness_level   = bri_r;

  a_word_in_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("accepted word produced no result at expected latency");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted word");

  a_interp_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !pass2_r) |->
      (x2_r > kli_pkg::kf_pos(lo2_r)) && (x2_r < kli_pkg::kf_pos(hi2_r)))
    else $error("interpolation neighbours do not bracket the input");

endmodule

FILE: hdl/kli_div_pipe.sv
// ----------------------------------------------------------------------------
// kli_div_pipe
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per stage. The numerator must stay below divisor << DATA_W.
// ----------------------------------------------------------------------------
module kli_div_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  kli_pkg::prod_t        in_num_t,
  input  kli_pkg::prod_t        in_num_b,
  input  kli_pkg::data_t        in_den,
  input  kli_pkg::side_t        in_side,
  output logic                  out_vld,
  output kli_pkg::data_t        out_quo_t,
  output kli_pkg::data_t        out_quo_b,
  output kli_pkg::side_t        out_side
);

  localparam int unsigned NS = kli_pkg::DIV_STAGES;

  logic                 vld_r    [NS];
  kli_pkg::prod_t       acc_t_r  [NS];
  kli_pkg::prod_t       acc_b_r  [NS];
  kli_pkg::data_t       den_r    [NS];
  kli_pkg::side_t       side_r   [NS];

  logic                 vld_nxt  [NS];
  kli_pkg::prod_t       acc_t_nxt[NS];
  kli_pkg::prod_t       acc_b_nxt[NS];
  kli_pkg::data_t       den_nxt  [NS];
  kli_pkg::side_t       side_nxt [NS];

  always_comb begin
    vld_nxt[0]   = in_vld;
    acc_t_nxt[0] = kli_pkg::div_step(in_num_t, in_den);
    acc_b_nxt[0] = kli_pkg::div_step(in_num_b, in_den);
    den_nxt[0]   = in_den;
    side_nxt[0]  = in_side;
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k]   = vld_r[k-1];
      acc_t_nxt[k] = kli_pkg::div_step(acc_t_r[k-1], den_r[k-1]);
      acc_b_nxt[k] = kli_pkg::div_step(acc_b_r[k-1], den_r[k-1]);
      den_nxt[k]   = den_r[k-1];
      side_nxt[k]  = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      acc_t_r[k] <= acc_t_nxt[k];
      acc_b_r[k] <= acc_b_nxt[k];
      den_r[k]   <= den_nxt[k];
      side_r[k]  <= side_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NS; k++) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  assign out_vld   = vld_r[NS-1];
  assign out_quo_t = acc_t_r[NS-1][kli_pkg::DATA_W-1:0];
  assign out_quo_b = acc_b_r[NS-1][kli_pkg::DATA_W-1:0];
  assign out_side  = side_r[NS-1];

  // quotient must fit the lane width
  a_num_headroom_t: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> (in_num_t[kli_pkg::PROD_W-1 -: kli_pkg::DATA_W] < in_den))
    else $error("divider lane t numerator overflows quotient width");

  a_num_headroom_b: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> (in_num_b[kli_pkg::PROD_W-1 -: kli_pkg::DATA_W] < in_den))
    else $error("divider lane b numerator overflows quotient width");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> (in_den != '0))
    else $error("divider fed a zero divisor");

endmodule
